// ----- src/cfa_pkg.sv -----
`default_nettype none

package cfa_pkg;

    localparam int MAX_POOL_FRAMES_DEF = 4096;

    localparam int FRAME_W  = 20;
    localparam int COUNT_W  = 13;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int STATE_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] POOL_RESET = COUNT_W'(4096);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FRAMES = 1'd1;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd2;

    localparam logic [STATE_W-1:0] FS_FREE = 2'd0;
    localparam logic [STATE_W-1:0] FS_HEAD = 2'd1;
    localparam logic [STATE_W-1:0] FS_USED = 2'd2;

    localparam logic [STATUS_W-1:0] RS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] RS_NO_RUN    = 3'd1;
    localparam logic [STATUS_W-1:0] RS_OUTSIDE   = 3'd2;
    localparam logic [STATUS_W-1:0] RS_NOT_HEAD  = 3'd3;
    localparam logic [STATUS_W-1:0] RS_BAD_COUNT = 3'd4;

endpackage

`default_nettype wire

// ----- src/cfa_store.sv -----
`default_nettype none

module cfa_store
    import cfa_pkg::*;
#(
    parameter int DEPTH = MAX_POOL_FRAMES_DEF,
    parameter int AW    = $clog2(MAX_POOL_FRAMES_DEF)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [STATE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [STATE_W-1:0] o_rdata,
    output logic                    o_busy
);

    logic [STATE_W-1:0] r_mem [DEPTH];
    logic [STATE_W-1:0] r_rdata;
    logic               r_busy;
    logic [AW-1:0]      r_clr_ptr;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [STATE_W-1:0] wdata;

    // clearing pass after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_ptr <= '0;
        end else if (r_busy) begin
            r_clr_ptr <= r_clr_ptr + 1'b1;
            if (r_clr_ptr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_busy) begin
            we    = 1'b1;
            waddr = r_clr_ptr;
            wdata = FS_FREE;
        end else begin
            we    = i_we;
            waddr = i_waddr;
            wdata = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

// ----- src/contiguous_frame_allocator_core.sv -----
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------
// request  | in        | i_in_valid / o_in_stall   | i_kind, i_frame_no, i_count
// result   | out       | o_out_valid / i_out_stall | o_status, o_first_frame
// config   | in        | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// one beat at a time: a request holds the input stalled until its result is queued
// allocate scans for a free run of i_count frames and marks it; release frees the head
// and the used frames after it; mark writes i_count frames; early rejects skip to result
// the scan reads the state store once per cycle through its single read port
// after reset a clearing pass over all MAX_POOL_FRAMES store entries holds the input stalled
// a result may wait under i_out_stall while the next request is taken
`default_nettype none

module contiguous_frame_allocator_core
    import cfa_pkg::*;
#(
    parameter int MAX_POOL_FRAMES = MAX_POOL_FRAMES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [FRAME_W-1:0]   i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic [FRAME_W-1:0]   i_frame_no,
    input  wire logic [COUNT_W-1:0]   i_count,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [STATUS_W-1:0]  o_status,
    output logic      [FRAME_W-1:0]   o_first_frame
);

    localparam int AW  = $clog2(MAX_POOL_FRAMES);
    localparam int NWM = $clog2(MAX_POOL_FRAMES + 1);
    localparam int NW  = (NWM > COUNT_W) ? NWM : COUNT_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_POOL_FRAMES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MARK = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [FRAME_W-1:0]  r_base;
    logic [COUNT_W-1:0]  r_pool;

    logic [1:0]          r_state, n_state;
    logic [KIND_W-1:0]   r_mode, n_mode;
    logic [NW-1:0]       r_ptr, n_ptr;
    logic                r_cvld, n_cvld;
    logic [AW-1:0]       r_cidx, n_cidx;
    logic [NW-1:0]       r_run, n_run;
    logic [NW-1:0]       r_cnt, n_cnt;
    logic [AW-1:0]       r_start, n_start;
    logic [AW-1:0]       r_end, n_end;
    logic [AW-1:0]       r_wptr, n_wptr;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [FRAME_W-1:0]  r_first, n_first;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [FRAME_W-1:0]  r_out_first, n_out_first;

    logic [NW-1:0]       pool_n;
    logic [NW-1:0]       pool_last;
    logic [FRAME_W-1:0]  req_idx;
    logic [FRAME_W-1:0]  room;
    logic [NW-1:0]       cnt_w;
    logic [NW-1:0]       run_nx;
    logic [NW-1:0]       alloc_start;
    logic                at_last;

    logic                st_we;
    logic [AW-1:0]       st_waddr;
    logic [STATE_W-1:0]  st_wdata;
    logic [AW-1:0]       st_raddr;
    logic [STATE_W-1:0]  st_rdata;
    logic                st_busy;

    cfa_store #(
        .DEPTH (MAX_POOL_FRAMES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata),
        .o_busy  (st_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_pool <= POOL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BASE_FRAME) begin
                r_base <= i_cfg_data;
            end else begin
                r_pool <= i_cfg_data[COUNT_W-1:0];
            end
        end
    end

    assign pool_n      = (NW'(r_pool) > MAX_N) ? MAX_N : NW'(r_pool);
    assign pool_last   = pool_n - 1'b1;
    assign req_idx     = i_frame_no - r_base;
    assign room        = FRAME_W'(pool_n) - req_idx;
    assign cnt_w       = NW'(i_count);
    assign run_nx      = (st_rdata == FS_FREE) ? r_run + 1'b1 : '0;
    assign alloc_start = NW'(r_cidx) + 1'b1 - r_cnt;
    assign at_last     = (NW'(r_cidx) == pool_last);

    assign o_in_stall = st_busy || (r_state != S_IDLE);
    assign st_raddr   = r_ptr[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_ptr        = r_ptr;
        n_cvld       = 1'b0;
        n_cidx       = r_ptr[AW-1:0];
        n_run        = r_run;
        n_cnt        = r_cnt;
        n_start      = r_start;
        n_end        = r_end;
        n_wptr       = r_wptr;
        n_status     = r_status;
        n_first      = r_first;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_first  = r_out_first;
        st_we        = 1'b0;
        st_waddr     = r_wptr;
        st_wdata     = FS_USED;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    n_mode   = i_kind;
                    n_status = RS_OK;
                    n_first  = '0;
                    n_cnt    = cnt_w;
                    n_run    = '0;
                    n_state  = S_RESP;
                    case (i_kind)
                        KIND_ALLOC: begin
                            if (i_count == '0 || cnt_w > pool_n) begin
                                n_status = RS_BAD_COUNT;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        KIND_RELEASE: begin
                            if (req_idx >= FRAME_W'(pool_n)) begin
                                n_status = RS_OUTSIDE;
                            end else begin
                                n_ptr   = NW'(req_idx);
                                n_start = req_idx[AW-1:0];
                                n_state = S_SCAN;
                            end
                        end
                        KIND_MARK: begin
                            if (i_count == '0) begin
                                n_status = RS_BAD_COUNT;
                            end else if (req_idx >= FRAME_W'(pool_n)
                                         || FRAME_W'(i_count) > room) begin
                                n_status = RS_OUTSIDE;
                            end else begin
                                n_start = req_idx[AW-1:0];
                                n_wptr  = req_idx[AW-1:0];
                                n_end   = AW'(NW'(req_idx[AW-1:0]) + cnt_w - 1'b1);
                                n_state = S_MARK;
                            end
                        end
                        default: begin
                            n_status = RS_OK;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_ptr < pool_n) begin
                    n_ptr  = r_ptr + 1'b1;
                    n_cvld = 1'b1;
                end
                if (r_cvld) begin
                    if (r_mode == KIND_ALLOC) begin
                        n_run = run_nx;
                        if (run_nx == r_cnt) begin
                            n_start = alloc_start[AW-1:0];
                            n_wptr  = alloc_start[AW-1:0];
                            n_end   = r_cidx;
                            n_first = r_base + FRAME_W'(alloc_start[AW-1:0]);
                            n_cvld  = 1'b0;
                            n_state = S_MARK;
                        end else if (at_last) begin
                            n_status = RS_NO_RUN;
                            n_cvld   = 1'b0;
                            n_state  = S_RESP;
                        end
                    end else if (r_cidx == r_start) begin
                        if (st_rdata != FS_HEAD) begin
                            n_status = RS_NOT_HEAD;
                            n_cvld   = 1'b0;
                            n_state  = S_RESP;
                        end else begin
                            st_we    = 1'b1;
                            st_waddr = r_cidx;
                            st_wdata = FS_FREE;
                            if (at_last) begin
                                n_cvld  = 1'b0;
                                n_state = S_RESP;
                            end
                        end
                    end else if (st_rdata == FS_USED) begin
                        st_we    = 1'b1;
                        st_waddr = r_cidx;
                        st_wdata = FS_FREE;
                        if (at_last) begin
                            n_cvld  = 1'b0;
                            n_state = S_RESP;
                        end
                    end else begin
                        n_cvld  = 1'b0;
                        n_state = S_RESP;
                    end
                end
            end

            S_MARK: begin
                st_we    = 1'b1;
                st_waddr = r_wptr;
                st_wdata = (r_wptr == r_start) ? FS_HEAD : FS_USED;
                n_wptr   = r_wptr + 1'b1;
                if (r_wptr == r_end) begin
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_first  = (r_status == RS_OK) ? r_first : '0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cvld      <= n_cvld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_ptr        <= n_ptr;
        r_cidx       <= n_cidx;
        r_run        <= n_run;
        r_cnt        <= n_cnt;
        r_start      <= n_start;
        r_end        <= n_end;
        r_wptr       <= n_wptr;
        r_status     <= n_status;
        r_first      <= n_first;
        r_out_status <= n_out_status;
        r_out_first  <= n_out_first;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_first_frame = r_out_first;

endmodule

`default_nettype wire

// ----- src/cfa_checker.sv -----
`default_nettype none

module cfa_checker
    import cfa_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [FRAME_W-1:0]  o_first_frame
);

    // a request beat is followed by a stalled input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_first_frame)))
        else $error("stalled result beat changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != RS_OK) |-> (o_first_frame == '0))
        else $error("failed request carries a frame number");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= RS_BAD_COUNT))
        else $error("status code out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

endmodule

bind contiguous_frame_allocator_core cfa_checker u_cfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_first_frame (o_first_frame)
);

`default_nettype wire
